### design/hbpm_pkg.sv
// shared types, codes and constants of the hex/binary pattern matcher
package hbpm_pkg;

  localparam int DataLenW           = 16;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // status codes
  localparam logic [1:0] ST_RUN      = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_SYNTAX   = 2'd3;

  // pattern characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h3c;
  localparam logic [7:0] CH_CLOSE = 8'h3e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [7:0] HI_NIBBLE = 8'hf0;
  localparam logic [7:0] LO_NIBBLE = 8'h0f;

  localparam logic [2:0] POS_HIGH = 3'd0;
  localparam logic [2:0] POS_LOW  = 3'd4;

  // bit selector, msb first
  localparam logic [7:0] BIT_MASK [8] = '{8'h80, 8'h40, 8'h20, 8'h10,
                                          8'h08, 8'h04, 8'h02, 8'h01};

  typedef struct packed {
    logic [7:0] pattern_char;
    logic [7:0] data_byte;
    logic       first_char;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic       binary_mode;
    logic [2:0] bit_position;
    logic [1:0] verdict;
    logic       done_flag;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] status;
    logic       byte_advance;
    logic       finished;
  } res_t;

  // upper-case hex digit decode: {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = c - CH_ZERO;
        return {1'b1, v[3:0]};
      end
      if (c >= CH_UA && c <= CH_UF) begin
        v = c - CH_UA + 8'd10;
        return {1'b1, v[3:0]};
      end
      return 5'b0_0000;
    end
  endfunction

endpackage

### design/hbpm_if.sv
// channel interfaces: pattern transactions in, result transactions out
interface hbpm_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_char;
  logic [7:0] data_byte;
  logic       first_char;
  logic       last_char;

  modport source (output valid, pattern_char, data_byte, first_char, last_char,
                  input ready);
  modport sink (input valid, pattern_char, data_byte, first_char, last_char,
                output ready);
endinterface

interface hbpm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        byte_advance;
  logic [15:0] matched_bytes;
  logic        finished;

  modport source (output valid, status, byte_advance, matched_bytes, finished,
                  input ready);
  modport sink (input valid, status, byte_advance, matched_bytes, finished,
                output ready);
endinterface

### design/hbpm_step.sv
// next-state and result logic for one pattern character
module hbpm_step import hbpm_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  item_t                  item,
  input  ctrl_t                  ctrl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [DataLenW-1:0]    data_length,
  output ctrl_t                  ctrl_next,
  output logic [COUNT_WIDTH-1:0] count_next,
  output res_t                   res
);

  localparam int CmpW = (COUNT_WIDTH > DataLenW) ? COUNT_WIDTH : DataLenW;

  ctrl_t                  cs;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [4:0]             hv;
  logic [2:0]             pos;
  logic                   data_bit;
  logic                   want_bit;
  logic                   adv;
  logic                   mism;
  logic                   ok;
  logic                   nib_edge;
  logic                   exhausted_now;
  logic                   exhausted_inc;

  always_comb begin
    cs  = item.first_char ? ctrl_t'{binary_mode: 1'b0, bit_position: POS_HIGH,
                                    verdict: ST_RUN, done_flag: 1'b0} : ctrl;
    cnt = item.first_char ? '0 : count;
  end

  assign hv       = hex_value(item.pattern_char);
  assign pos      = cs.bit_position;
  assign nib_edge = (pos == POS_HIGH) || (pos == POS_LOW);
  assign data_bit = (item.data_byte & BIT_MASK[pos]) != 8'h00;
  assign want_bit = (item.pattern_char == CH_ONE);

  assign exhausted_now = (CmpW'(cnt) >= CmpW'(data_length)) || (&cnt);

  always_comb begin
    ctrl_next     = cs;
    count_next    = cnt;
    cnt_inc       = cnt;
    exhausted_inc = 1'b0;
    adv           = 1'b0;
    mism          = 1'b0;
    ok            = 1'b1;
    if (!cs.done_flag) begin
      if (exhausted_now) begin
        ctrl_next.verdict   = ST_MATCH;
        ctrl_next.done_flag = 1'b1;
      end else if (item.pattern_char == CH_NUL) begin
        ctrl_next.verdict   = (pos == POS_HIGH) ? ST_MATCH : ST_SYNTAX;
        ctrl_next.done_flag = 1'b1;
      end else begin
        priority if (item.pattern_char == CH_SPACE) begin
          // skipped
        end else if (!cs.binary_mode && item.pattern_char == CH_OPEN && nib_edge) begin
          ctrl_next.binary_mode = 1'b1;
        end else if (cs.binary_mode && item.pattern_char == CH_CLOSE && nib_edge) begin
          ctrl_next.binary_mode = 1'b0;
        end else if (cs.binary_mode &&
                     (item.pattern_char == CH_ZERO || item.pattern_char == CH_ONE)) begin
          if (data_bit != want_bit) begin
            mism = 1'b1;
          end else begin
            ctrl_next.bit_position = pos + 3'd1;
            adv = (pos == 3'd7);
          end
        end else if (!cs.binary_mode && hv[4] && pos == POS_HIGH) begin
          if ((item.data_byte & HI_NIBBLE) != {hv[3:0], 4'h0}) begin
            mism = 1'b1;
          end else begin
            ctrl_next.bit_position = POS_LOW;
          end
        end else if (!cs.binary_mode && hv[4] && pos == POS_LOW) begin
          if ((item.data_byte & LO_NIBBLE) != {4'h0, hv[3:0]}) begin
            mism = 1'b1;
          end else begin
            ctrl_next.bit_position = POS_HIGH;
            adv = 1'b1;
          end
        end else begin
          ok = 1'b0;
        end

        if (mism) begin
          ctrl_next              = cs;
          ctrl_next.verdict      = ST_MISMATCH;
          ctrl_next.done_flag    = 1'b1;
          adv                    = 1'b0;
        end else if (!ok) begin
          ctrl_next.verdict   = ST_SYNTAX;
          ctrl_next.done_flag = 1'b1;
        end else begin
          cnt_inc       = cnt + COUNT_WIDTH'(adv);
          exhausted_inc = (CmpW'(cnt_inc) >= CmpW'(data_length)) || (&cnt_inc);
          count_next    = cnt_inc;
          if (exhausted_inc) begin
            ctrl_next.verdict   = ST_MATCH;
            ctrl_next.done_flag = 1'b1;
          end else if (item.last_char) begin
            ctrl_next.verdict   = (ctrl_next.bit_position == POS_HIGH) ? ST_MATCH : ST_SYNTAX;
            ctrl_next.done_flag = 1'b1;
          end
        end
      end
    end
  end

  assign res.status       = ctrl_next.done_flag ? ctrl_next.verdict : ST_RUN;
  assign res.byte_advance = adv;
  assign res.finished     = ctrl_next.done_flag;

endmodule

### design/hex_binary_pattern_matcher.sv
// top level of the hex/binary pattern matcher
//
// usage: the feeder sends one transaction per pattern character on the item
// channel, carrying the character and the data byte at the current match
// position; first_char opens a job and clears the match state, last_char
// marks the final character. each item gives exactly one result transaction
// with the running status, a byte_advance flag (present the next data byte),
// the count of whole bytes matched and a finished flag. data_length is set
// via wr_en/wr_data, by the user between jobs (the block does not enforce
// it), and is sampled live by every item.
// timing: the item is captured in the input register, then its result in the
// result register, where it is presented. throughput: one item per cycle while
// the receiver takes results, since the per-character step is a compare and a
// few state bits between the registers.
//
// reset (synchronous, rst high) empties both pipeline registers, clears the
// match state and sets data_length to zero. when the receiver stalls, the
// result register holds and one further item may wait in the input
// register; item.ready then drops until the result is taken.
module hex_binary_pattern_matcher import hbpm_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  hbpm_item_if.sink           item,
  hbpm_result_if.source       result,
  input  logic                wr_en,
  input  logic [DataLenW-1:0] wr_data
);

  // configuration
  logic [DataLenW-1:0] data_length;

  // input register
  logic  in_valid;
  item_t item_q;

  // match state
  ctrl_t                  ctrl;
  logic [COUNT_WIDTH-1:0] count;

  // step outputs
  ctrl_t                  ctrl_next;
  logic [COUNT_WIDTH-1:0] count_next;
  res_t                   res;

  // result register
  logic                out_valid;
  res_t                res_q;
  logic [DataLenW-1:0] matched_q;

  logic take;     // transaction accepted on the item channel
  logic advance;  // input register moves into the result register

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= '0;
    end else if (wr_en) begin
      data_length <= wr_data;
    end
  end

  // input register, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_q <= '{pattern_char: item.pattern_char, data_byte: item.data_byte,
                  first_char: item.first_char, last_char: item.last_char};
    end
  end

  hbpm_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .item        (item_q),
    .ctrl        (ctrl),
    .count       (count),
    .data_length (data_length),
    .ctrl_next   (ctrl_next),
    .count_next  (count_next),
    .res         (res)
  );

  // match state moves on as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl  <= '{binary_mode: 1'b0, bit_position: POS_HIGH,
                 verdict: ST_RUN, done_flag: 1'b0};
      count <= '0;
    end else if (advance) begin
      ctrl  <= ctrl_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q     <= res;
      matched_q <= DataLenW'(count_next);
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = res_q.status;
  assign result.byte_advance  = res_q.byte_advance;
  assign result.matched_bytes = matched_q;
  assign result.finished      = res_q.finished;

  // a finished result always carries a final verdict, a running one never
  a_fin_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_q.finished == (res_q.status != ST_RUN)))
    else $error("finished flag and status disagree");

  // in hex mode only the nibble boundaries are reachable
  a_hex_pos: assert property (@(posedge clk) disable iff (rst)
    !ctrl.binary_mode |-> (ctrl.bit_position[1:0] == 2'b00))
    else $error("hex mode off a nibble boundary");

  // a stalled result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> ($stable(res_q) && $stable(matched_q)))
    else $error("stalled result overwritten");

  // the count only changes by one byte on an advance
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (advance && !item_q.first_char && !ctrl.done_flag && !res.byte_advance)
      |=> $stable(count))
    else $error("byte count moved without a byte advance");

endmodule

### tb/hbpm_checker.sv
// checker for the hex/binary pattern matcher: predicts each result and compares it
module hbpm_checker import hbpm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  hbpm_item_if                item,
  hbpm_result_if              result,
  input  logic                wr_en,
  input  logic [DataLenW-1:0] wr_data,
  output int                  fail_count,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef struct packed {
    logic [1:0]  status;
    logic        byte_advance;
    logic [15:0] matched_bytes;
    logic        finished;
  } outcome_t;

  logic [DataLenW-1:0] data_len;
  logic                in_binary;
  logic [2:0]          bit_pos;
  logic [15:0]         bytes_done;
  logic [1:0]          verdict;
  logic                job_done;
  outcome_t            outcomes_due[$];
  outcome_t            wanted;

  initial fail_count = 0;

  task automatic report_error(input string what, input int got, input int exp_val);
    $display("%0t ns: %s got %0h wanted %0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  // {is digit, value} for an upper-case hex character
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE)
      return {1'b1, c[3:0]};
    if (c >= CH_UA && c <= CH_UF)
      return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void close_job(input logic [1:0] v);
    verdict  = v;
    job_done = 1'b1;
  endfunction

  function automatic outcome_t step_matcher(input item_t it);
    outcome_t   o;
    logic       adv;
    logic       mism;
    logic       ok;
    logic       boundary;
    logic [4:0] dig;
    logic [7:0] c;
    adv  = 1'b0;
    mism = 1'b0;
    ok   = 1'b1;
    c    = it.pattern_char;
    if (it.first_char) begin
      in_binary  = 1'b0;
      bit_pos    = POS_HIGH;
      bytes_done = '0;
      verdict    = ST_RUN;
      job_done   = 1'b0;
    end
    if (!job_done) begin
      if (bytes_done >= data_len || bytes_done == COUNT_MAX) begin
        close_job(ST_MATCH);
      end else if (c == CH_NUL) begin
        close_job(bit_pos == POS_HIGH ? ST_MATCH : ST_SYNTAX);
      end else begin
        dig      = digit_of(c);
        boundary = (bit_pos == POS_HIGH) || (bit_pos == POS_LOW);
        if (c == CH_SPACE) begin
          // skipped
        end else if (!in_binary && c == CH_OPEN && boundary) begin
          in_binary = 1'b1;
        end else if (in_binary && c == CH_CLOSE && boundary) begin
          in_binary = 1'b0;
        end else if (in_binary && (c == CH_ZERO || c == CH_ONE)) begin
          if (it.data_byte[3'd7 - bit_pos] != c[0]) begin
            mism = 1'b1;
          end else if (bit_pos == 3'd7) begin
            bit_pos = POS_HIGH;
            adv     = 1'b1;
          end else begin
            bit_pos = bit_pos + 3'd1;
          end
        end else if (!in_binary && dig[4] && bit_pos == POS_HIGH) begin
          if (it.data_byte[7:4] != dig[3:0]) mism = 1'b1;
          else bit_pos = POS_LOW;
        end else if (!in_binary && dig[4] && bit_pos == POS_LOW) begin
          if (it.data_byte[3:0] != dig[3:0]) begin
            mism = 1'b1;
          end else begin
            bit_pos = POS_HIGH;
            adv     = 1'b1;
          end
        end else begin
          ok = 1'b0;
        end

        if (mism) begin
          close_job(ST_MISMATCH);
        end else if (!ok) begin
          close_job(ST_SYNTAX);
        end else begin
          if (adv) bytes_done = bytes_done + 16'd1;
          if (bytes_done >= data_len || bytes_done == COUNT_MAX)
            close_job(ST_MATCH);
          else if (it.last_char)
            close_job(bit_pos == POS_HIGH ? ST_MATCH : ST_SYNTAX);
        end
      end
    end
    o.status        = job_done ? verdict : ST_RUN;
    o.byte_advance  = adv;
    o.matched_bytes = bytes_done;
    o.finished      = job_done;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      data_len   = '0;
      in_binary  = 1'b0;
      bit_pos    = POS_HIGH;
      bytes_done = '0;
      verdict    = ST_RUN;
      job_done   = 1'b0;
      outcomes_due.delete();
      outstanding <= 0;
    end else begin
      if (wr_en) data_len = wr_data;
      if (item.valid === 1'b1 && item.ready === 1'b1)
        outcomes_due.push_back(step_matcher({item.pattern_char, item.data_byte,
                                             item.first_char, item.last_char}));
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (outcomes_due.size() == 0) begin
          report_error("unexpected result, status", result.status, 0);
        end else begin
          wanted = outcomes_due.pop_front();
          if (result.status !== wanted.status)
            report_error("status", result.status, wanted.status);
          if (result.byte_advance !== wanted.byte_advance)
            report_error("byte_advance", result.byte_advance, wanted.byte_advance);
          if (result.matched_bytes !== wanted.matched_bytes)
            report_error("matched_bytes", result.matched_bytes, wanted.matched_bytes);
          if (result.finished !== wanted.finished)
            report_error("finished", result.finished, wanted.finished);
        end
      end
      outstanding <= outcomes_due.size();
    end
  end

endmodule

### tb/tb.sv
// testbench top: clock, reset, pattern stimulus and verdict for the pattern matcher
module tb import hbpm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET  = 1950;
  localparam int          PHASE_ITEMS  = 130;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RESET_CYCLES = 6;
  localparam logic [7:0]  CH_LOWER_A   = 8'h61;
  // structural characters used by the noise jobs
  localparam logic [7:0]  MARKS [4]    = '{CH_OPEN, CH_CLOSE, CH_SPACE, CH_NUL};

  logic                clk = 1'b0;
  logic                rst;
  logic                wr_en;
  logic [DataLenW-1:0] wr_data;
  int                  fails;
  int                  outstanding;

  // calm: neither side idles; hold requests ask the receiver for one long stall
  bit                  calm = 1'b0;
  int                  hold_requests = 0;
  int                  holds_granted = 0;
  int                  items_sent = 0;

  // one job's worth of pattern transactions, built first and then sent
  item_t               job_q[$];
  logic [7:0]          job_data[$];

  hbpm_item_if   item_ch();
  hbpm_result_if result_ch();

  hex_binary_pattern_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  hbpm_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .fail_count  (fails),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // hard limit, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, plus one long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int wait_cycles;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_granted != hold_requests) begin
        // long stall: the block fills up and has to push back on its input
        holds_granted++;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = calm ? 0 : $urandom_range(0, 3);
      end
      if (wait_cycles != 0) begin
        result_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // helpers for building and sending jobs
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UA + 8'(n) - 8'd10;
  endfunction

  function automatic void push_item(input logic [7:0] c, input logic [7:0] d,
                                    input bit first, input bit last);
    item_t it;
    it.pattern_char = c;
    it.data_byte    = d;
    it.first_char   = first;
    it.last_char    = last;
    job_q.push_back(it);
  endfunction

  // the very first character of a job opens it
  function automatic void push_char(input logic [7:0] c, input logic [7:0] d);
    push_item(c, d, job_q.size() == 0, 1'b0);
  endfunction

  // a pattern that matches its data byte for byte, mixing hex digits and
  // binary runs that open and close on nibble boundaries, with stray spaces
  function automatic void build_good_job(input int nbytes);
    bit         binary;
    bit         next_bin;
    logic [3:0] nib;
    logic [7:0] cur;
    for (int b = 0; b < nbytes; b++) job_data.push_back(8'($urandom));
    binary = 1'b0;
    for (int b = 0; b < nbytes; b++) begin
      cur = job_data[b];
      for (int h = 0; h < 2; h++) begin
        if ($urandom_range(0, 7) == 0) push_char(CH_SPACE, cur);
        next_bin = ($urandom_range(0, 2) == 0) ? !binary : binary;
        if (next_bin != binary) push_char(binary ? CH_CLOSE : CH_OPEN, cur);
        binary = next_bin;
        nib = (h == 0) ? cur[7:4] : cur[3:0];
        if (binary) begin
          for (int k = 3; k >= 0; k--) push_char(nib[k] ? CH_ONE : CH_ZERO, cur);
        end else begin
          push_char(hex_char(nib), cur);
        end
      end
    end
    // a trailing close is optional, the byte behind the data is arbitrary
    if (binary && $urandom_range(0, 1) == 1) push_char(CH_CLOSE, 8'($urandom));
  endfunction

  // end marker of the job, and now and then one damaged transaction
  function automatic void end_and_break_job();
    int idx;
    case ($urandom_range(0, 3))
      0, 1: job_q[job_q.size() - 1].last_char = 1'b1;
      2: push_char(CH_NUL, 8'($urandom));
      default: ;  // no end marker, the next job's first character cuts it off
    endcase
    if ($urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, job_q.size() - 1);
      case ($urandom_range(0, 4))
        0: job_q[idx].pattern_char = 8'($urandom);
        1: job_q[idx].data_byte = job_q[idx].data_byte ^ 8'(1 << $urandom_range(0, 7));
        2: job_q[idx].pattern_char = CH_LOWER_A + 8'($urandom_range(0, 5));
        3: job_q[idx].last_char = 1'b1;
        default: job_q[idx].pattern_char = CH_NUL;
      endcase
    end
  endfunction

  // random characters with random job markers
  function automatic void build_noise_job(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom);
        1: c = hex_char(4'($urandom));
        2: c = ($urandom_range(0, 1) == 1) ? CH_ONE : CH_ZERO;
        default: c = MARKS[$urandom_range(0, 3)];
      endcase
      push_item(c, 8'($urandom), i == 0 || $urandom_range(0, 15) == 0,
                $urandom_range(0, 15) == 0);
    end
  endfunction

  // one transaction, after a random gap; valid stays high when there is no gap
  task automatic send_item(input item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.pattern_char <= it.pattern_char;
    item_ch.data_byte    <= it.data_byte;
    item_ch.first_char   <= it.first_char;
    item_ch.last_char    <= it.last_char;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_job();
    foreach (job_q[i]) send_item(job_q[i]);
    job_q.delete();
    job_data.delete();
  endtask

  // sender pauses until every outstanding result has been taken
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_len(input logic [DataLenW-1:0] v);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int phase_start;
    rst                  <= 1'b1;
    wr_en                <= 1'b0;
    wr_data              <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.pattern_char <= '0;
    item_ch.data_byte    <= '0;
    item_ch.first_char   <= 1'b0;
    item_ch.last_char    <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // data_length is still zero from reset: the job ends at once as matched,
    // and a finished job ignores what follows
    push_item(hex_char(4'hA), 8'hab, 1'b1, 1'b0);
    push_item(8'hff, 8'h00, 1'b0, 1'b0);
    send_job();
    wait_idle();
    write_len(16'd2);

    // binary run over the high nibble, close on the nibble boundary, hex low nibble
    push_item(CH_OPEN, 8'ha5, 1'b1, 1'b0);
    push_item(CH_ONE,  8'ha5, 1'b0, 1'b0);
    push_item(CH_ZERO, 8'ha5, 1'b0, 1'b0);
    push_item(CH_ONE,  8'ha5, 1'b0, 1'b0);
    push_item(CH_ZERO, 8'ha5, 1'b0, 1'b0);
    push_item(CH_CLOSE, 8'ha5, 1'b0, 1'b0);
    push_item(hex_char(4'h5), 8'ha5, 1'b0, 1'b0);
    // space skipped, second byte uses up the data, the next character is ignored
    push_item(CH_SPACE, 8'hff, 1'b0, 1'b0);
    push_item(hex_char(4'hF), 8'hff, 1'b0, 1'b0);
    push_item(hex_char(4'hF), 8'hff, 1'b0, 1'b0);
    push_item(hex_char(4'h0), 8'h00, 1'b0, 1'b0);
    // lower-case hex digit is a syntax error
    push_item(CH_LOWER_A, 8'ha0, 1'b1, 1'b0);
    // nul on a partial byte
    push_item(hex_char(4'h1), 8'h1f, 1'b1, 1'b0);
    push_item(CH_NUL, 8'h1f, 1'b0, 1'b0);
    // close off a nibble boundary
    push_item(CH_OPEN, 8'h80, 1'b1, 1'b0);
    push_item(CH_ONE, 8'h80, 1'b0, 1'b0);
    push_item(CH_CLOSE, 8'h80, 1'b0, 1'b0);
    // nested open
    push_item(CH_OPEN, 8'h00, 1'b1, 1'b0);
    push_item(CH_OPEN, 8'h00, 1'b0, 1'b0);
    // plain mismatch
    push_item(hex_char(4'hB), 8'hc0, 1'b1, 1'b0);
    // last character on a partial byte
    push_item(hex_char(4'h7), 8'h70, 1'b1, 1'b1);
    // job left half way through the second byte for the next step
    push_item(hex_char(4'h1), 8'h12, 1'b1, 1'b0);
    push_item(hex_char(4'h2), 8'h12, 1'b0, 1'b0);
    push_item(hex_char(4'h3), 8'h34, 1'b0, 1'b0);
    send_job();
    wait_idle();
    // data_length lowered to the count already reached: the job ends as matched
    write_len(16'd1);
    push_item(hex_char(4'h4), 8'h34, 1'b0, 1'b1);
    send_job();

    // random phases, each with its own data_length, extremes included
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case (phase % 6)
        0: write_len(16'hffff);
        1: write_len(16'd0);
        2: write_len(16'($urandom));
        default: write_len(16'($urandom_range(1, 8)));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 3) hold_requests++;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 6) == 0) begin
          build_noise_job($urandom_range(1, 12));
        end else begin
          build_good_job($urandom_range(1, 6));
          end_and_break_job();
        end
        send_job();
      end
      phase++;
    end

    // drain, then keep the clock running so that any stray result shows
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
